// ----- src/mblb_pkg.sv -----
// ----------------------------------------------------------------------------
// mblb_pkg
// Types, codes and constants shared by the bitmap blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mblb_pkg;

    localparam logic [15:0] PANEL_LONG  = 16'd800;
    localparam logic [15:0] PANEL_SHORT = 16'd480;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    // configuration register indexes
    localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN  = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_FORE      = 3'd4;
    localparam logic [2:0] REG_BACK      = 3'd5;
    localparam logic [2:0] REG_LANDSCAPE = 3'd6;

    // write kinds
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_CMD = 2'd1;
    localparam logic [1:0] KIND_PIX = 2'd2;

    // controller commands and register addresses
    localparam logic [15:0] CMD_XS_HI = 16'h2A00;
    localparam logic [15:0] CMD_XS_LO = 16'h2A01;
    localparam logic [15:0] CMD_XE_HI = 16'h2A02;
    localparam logic [15:0] CMD_XE_LO = 16'h2A03;
    localparam logic [15:0] CMD_YS_HI = 16'h2B00;
    localparam logic [15:0] CMD_YS_LO = 16'h2B01;
    localparam logic [15:0] CMD_YE_HI = 16'h2B02;
    localparam logic [15:0] CMD_YE_LO = 16'h2B03;
    localparam logic [15:0] CMD_MEM_WR = 16'h2C00;
    localparam logic [15:0] CACHE_RESET = 16'hFFFF;

    typedef struct packed {
        logic [15:0] x_origin;
        logic [15:0] y_origin;
        logic [9:0]  bitmap_width;
        logic [9:0]  bitmap_height;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic        landscape;
    } t_cfg;

    typedef enum logic [3:0] {
        W_XS_HI, W_XS_LO, W_XE_HI, W_XE_LO,
        W_YS_HI, W_YS_LO, W_YE_HI, W_YE_LO,
        W_CMD, W_DATA
    } t_wsel;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEL_XS, ST_XS_LO, ST_SEL_XE, ST_XE_LO,
        ST_SEL_YS, ST_YS_LO, ST_SEL_YE, ST_YE_LO, ST_CMD, ST_DATA
    } t_state;

    typedef struct packed {
        logic  load;
        logic  emit;
        t_wsel wsel;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] diff;      // ye, ys, xe, xs differ from cache
        logic       item_end;  // current pixel ends the byte or the bitmap
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- src/mblb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mblb_cfg_regs
// APB register file holding origin, size, colors and orientation.
// ----------------------------------------------------------------------------
`default_nettype none

module mblb_cfg_regs
    import mblb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin      <= '0;
            r_cfg.y_origin      <= '0;
            r_cfg.bitmap_width  <= 10'd1;
            r_cfg.bitmap_height <= 10'd1;
            r_cfg.fore_color    <= '0;
            r_cfg.back_color    <= '0;
            r_cfg.landscape     <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_X_ORIGIN:  r_cfg.x_origin      <= pwdata[15:0];
                REG_Y_ORIGIN:  r_cfg.y_origin      <= pwdata[15:0];
                REG_WIDTH:     r_cfg.bitmap_width  <= pwdata[9:0];
                REG_HEIGHT:    r_cfg.bitmap_height <= pwdata[9:0];
                REG_FORE:      r_cfg.fore_color    <= pwdata[15:0];
                REG_BACK:      r_cfg.back_color    <= pwdata[15:0];
                REG_LANDSCAPE: r_cfg.landscape     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_X_ORIGIN:  prdata = {16'd0, r_cfg.x_origin};
            REG_Y_ORIGIN:  prdata = {16'd0, r_cfg.y_origin};
            REG_WIDTH:     prdata = {22'd0, r_cfg.bitmap_width};
            REG_HEIGHT:    prdata = {22'd0, r_cfg.bitmap_height};
            REG_FORE:      prdata = {16'd0, r_cfg.fore_color};
            REG_BACK:      prdata = {16'd0, r_cfg.back_color};
            REG_LANDSCAPE: prdata = {31'd0, r_cfg.landscape};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/mblb_datapath.sv -----
// ----------------------------------------------------------------------------
// mblb_datapath
// Pixel counters, window caches and the output write register.
// ----------------------------------------------------------------------------
`default_nettype none

module mblb_datapath
    import mblb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic [7:0]            i_byte,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [OUT_DATA_W-1:0] o_data,
    output logic                       o_last,
    output logic                       o_done
);

    logic [7:0]  r_bits;
    logic [2:0]  r_bit;
    logic [9:0]  r_col;
    logic [9:0]  r_row;
    logic [15:0] r_xs_c, r_xe_c, r_ys_c, r_ye_c;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_cmd_w;
    logic [15:0] r_data_w;
    logic        r_last;
    logic        r_done;

    logic [9:0]  w_eff, h_eff;
    logic        row_last, done, item_end;
    logic [15:0] xs, ys, xe, ye, color;
    logic [1:0]  n_kind;
    logic [15:0] n_cmd_w, n_data_w;
    logic        adv;

    assign w_eff    = (i_cfg.bitmap_width  == 10'd0) ? 10'd1 : i_cfg.bitmap_width;
    assign h_eff    = (i_cfg.bitmap_height == 10'd0) ? 10'd1 : i_cfg.bitmap_height;
    assign row_last = ({1'b0, r_row} + 11'd1) >= {1'b0, h_eff};
    assign done     = row_last && (({1'b0, r_col} + 11'd1) >= {1'b0, w_eff});
    assign item_end = done || (r_bit == 3'd7);
    assign xs       = i_cfg.x_origin + {6'd0, r_col};
    assign ys       = i_cfg.y_origin + {6'd0, r_row};
    assign xe       = i_cfg.landscape ? PANEL_LONG : PANEL_SHORT;
    assign ye       = i_cfg.landscape ? PANEL_SHORT : PANEL_LONG;
    assign color    = r_bits[r_bit] ? i_cfg.fore_color : i_cfg.back_color;
    assign adv      = i_cmd.emit && (i_cmd.wsel == W_DATA);

    assign o_status.diff     = {ye != r_ye_c, ys != r_ys_c, xe != r_xe_c, xs != r_xs_c};
    assign o_status.item_end = item_end;
    assign o_status.out_free = !r_out_valid || i_ready;

    always_comb begin
        n_kind   = KIND_REG;
        n_cmd_w  = '0;
        n_data_w = '0;
        case (i_cmd.wsel)
            W_XS_HI: begin n_cmd_w = CMD_XS_HI; n_data_w = {8'd0, xs[15:8]}; end
            W_XS_LO: begin n_cmd_w = CMD_XS_LO; n_data_w = {8'd0, xs[7:0]};  end
            W_XE_HI: begin n_cmd_w = CMD_XE_HI; n_data_w = {8'd0, xe[15:8]}; end
            W_XE_LO: begin n_cmd_w = CMD_XE_LO; n_data_w = {8'd0, xe[7:0]};  end
            W_YS_HI: begin n_cmd_w = CMD_YS_HI; n_data_w = {8'd0, ys[15:8]}; end
            W_YS_LO: begin n_cmd_w = CMD_YS_LO; n_data_w = {8'd0, ys[7:0]};  end
            W_YE_HI: begin n_cmd_w = CMD_YE_HI; n_data_w = {8'd0, ye[15:8]}; end
            W_YE_LO: begin n_cmd_w = CMD_YE_LO; n_data_w = {8'd0, ye[7:0]};  end
            W_CMD: begin
                n_kind  = KIND_CMD;
                n_cmd_w = CMD_MEM_WR;
            end
            W_DATA: begin
                n_kind   = KIND_PIX;
                n_data_w = color;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_xs_c      <= CACHE_RESET;
            r_xe_c      <= CACHE_RESET;
            r_ys_c      <= CACHE_RESET;
            r_ye_c      <= CACHE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_bit <= '0;
            end else if (adv) begin
                r_bit <= r_bit + 3'd1;
            end
            if (adv) begin
                if (done) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (row_last) begin
                    r_row <= '0;
                    r_col <= r_col + 10'd1;
                end else begin
                    r_row <= r_row + 10'd1;
                end
            end
            if (i_cmd.emit) begin
                case (i_cmd.wsel)
                    W_XS_LO: r_xs_c <= xs;
                    W_XE_LO: r_xe_c <= xe;
                    W_YS_LO: r_ys_c <= ys;
                    W_YE_LO: r_ye_c <= ye;
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bits <= i_byte;
        end
        if (i_cmd.emit) begin
            r_kind   <= n_kind;
            r_cmd_w  <= n_cmd_w;
            r_data_w <= n_data_w;
            r_last   <= adv && item_end;
            r_done   <= done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {6'd0, r_data_w, r_cmd_w, r_kind};
    assign o_last  = r_last;
    assign o_done  = r_done;

endmodule

`default_nettype wire

// ----- src/mblb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mblb_ctrl
// Sequencer choosing one bus write per cycle, while the output register is free, for each pixel of a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mblb_ctrl
    import mblb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [3:0] mask;
    logic [3:0] pend;
    t_wsel      sel_w;
    t_state     sel_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            ST_SEL_XS: mask = 4'b1111;
            ST_SEL_XE: mask = 4'b1110;
            ST_SEL_YS: mask = 4'b1100;
            ST_SEL_YE: mask = 4'b1000;
            default:   mask = 4'b0000;
        endcase
        pend = i_status.diff & mask;
        if (pend[0]) begin
            sel_w = W_XS_HI;
            sel_s = ST_XS_LO;
        end else if (pend[1]) begin
            sel_w = W_XE_HI;
            sel_s = ST_XE_LO;
        end else if (pend[2]) begin
            sel_w = W_YS_HI;
            sel_s = ST_YS_LO;
        end else if (pend[3]) begin
            sel_w = W_YE_HI;
            sel_s = ST_YE_LO;
        end else begin
            sel_w = W_CMD;
            sel_s = ST_DATA;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        o_cmd.wsel = W_CMD;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEL_XS;
                end
            end
            ST_SEL_XS, ST_SEL_XE, ST_SEL_YS, ST_SEL_YE: begin
                o_cmd.wsel = sel_w;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = sel_s;
                end
            end
            ST_XS_LO: begin
                o_cmd.wsel = W_XS_LO;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_SEL_XE;
                end
            end
            ST_XE_LO: begin
                o_cmd.wsel = W_XE_LO;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_SEL_YS;
                end
            end
            ST_YS_LO: begin
                o_cmd.wsel = W_YS_LO;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_SEL_YE;
                end
            end
            ST_YE_LO: begin
                o_cmd.wsel = W_YE_LO;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_CMD;
                end
            end
            ST_CMD: begin
                o_cmd.wsel = W_CMD;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.wsel = W_DATA;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.item_end ? ST_IDLE : ST_SEL_XS;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/mono_bitmap_lcd_blitter_top.sv -----
// ----------------------------------------------------------------------------
// mono_bitmap_lcd_blitter_top
// Expands 1-bit bitmap bytes into RGB565 LCD controller bus writes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one bitmap byte per transfer, bit 0 the earliest pixel,
//   pixels in column-major order. Master stream: one bus write per transfer,
//   tlast on the final write of a byte, tuser set on every write of the
//   bitmap's final pixel. The APB port sets origin, size, colors and
//   orientation; write it only while the block is idle.
//   Each pixel takes 2 to 10 writes: window register writes only where
//   the cached value changes, then the memory-write command and the pixel
//   word. A byte covers up to 8 pixels; the output register issues one write
//   per cycle while the master takes them. A byte is taken in the idle state,
//   which emits no write; its writes begin once the sequencer leaves idle.
//   The next byte is taken as soon as the final write of the previous one
//   sits in the output register. A master stall holds the write and freezes
//   the sequencer outside idle. Reset clears the pixel counters, sets the
//   window caches to all ones and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_lcd_blitter_top
    import mblb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] bitmap_byte
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [1:0] write_kind, [17:2] command_word, [33:18] data_word, [39:34] zero
    output logic      [OUT_DATA_W-1:0] o_m_tdata,
    output logic                       o_m_tlast,   // last_of_item
    output logic                       o_m_tuser,   // [0] blit_done
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    mblb_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mblb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mblb_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_cmd    (cmd),
        .o_status (status),
        .i_byte   (i_s_tdata),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata),
        .o_last   (o_m_tlast),
        .o_done   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- src/mblb_checker.sv -----
// ----------------------------------------------------------------------------
// mblb_checker
// Port-level assertions for the bitmap blitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mblb_checker
    import mblb_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                  o_m_tlast,
    input wire logic                  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled write changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("undefined write kind");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("byte taken while another is in progress");

    a_memwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] == KIND_CMD
            |-> o_m_tdata[17:2] == CMD_MEM_WR && o_m_tdata[33:18] == 16'd0)
        else $error("bad memory-write command");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[1:0] == KIND_PIX)
        else $error("end of byte not on a pixel word");

endmodule

bind mono_bitmap_lcd_blitter_top mblb_checker u_mblb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
